/* sv/msed_pkg.sv */
// Shared types, character codes and entity tables for the markup stripper.
`default_nettype none

package msed_pkg;

    // Scan mode of the text scanner
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ENTITY = 2'd1,
        MODE_TAG    = 2'd2
    } mode_t;

    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned NUM_PAT     = 5;

    typedef logic [2:0] slot_t;

    typedef struct packed {
        mode_t      scan_mode;
        logic [3:0] entity_progress;
        logic [1:0] tag_progress;
    } scan_state_t;

    // All result beats caused by one input byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        slot_t                       count;
        logic                        marker;
        logic                        last;
    } result_group_t;

    typedef struct packed {
        logic [2:0] pat;
        slot_t      len;
    } ent_pos_t;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_CASE = 8'h20;

    // Entity spellings: amp, lt, gt, quot, #39
    localparam logic [7:0] PAT_TEXT [NUM_PAT][6] = '{
        '{"&", "a", "m", "p", ";", 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "q", "u", "o", "t", ";"},
        '{"&", "#", "3", "9", ";", 8'h00}
    };
    localparam slot_t      PAT_LEN  [NUM_PAT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5};
    localparam logic [7:0] PAT_VAL  [NUM_PAT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};
    localparam logic [3:0] PAT_BASE [NUM_PAT] = '{4'd2, 4'd5, 4'd7, 4'd9, 4'd13};

    // Map an entity progress code to its entity and the number of bytes matched
    function automatic ent_pos_t ent_pos(input logic [3:0] s);
        ent_pos_t r;
        case (s) inside
            [4'd2:4'd4]:   begin r.pat = 3'd0; r.len = 3'(s);         end
            [4'd5:4'd6]:   begin r.pat = 3'd1; r.len = 3'(s - 4'd3);  end
            [4'd7:4'd8]:   begin r.pat = 3'd2; r.len = 3'(s - 4'd5);  end
            [4'd9:4'd12]:  begin r.pat = 3'd3; r.len = 3'(s - 4'd7);  end
            [4'd13:4'd15]: begin r.pat = 3'd4; r.len = 3'(s - 4'd11); end
            default:       begin r.pat = 3'd0; r.len = 3'd1;          end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/msed_decode.sv */
// Next-state and result-group logic for one text byte.
`default_nettype none

module msed_decode
    import msed_pkg::*;
(
    input  scan_state_t   st,
    input  logic [7:0]    text_byte,
    input  logic          text_last,
    output scan_state_t   st_next,
    output result_group_t grp
);

    ent_pos_t    pos_a;
    ent_pos_t    pos_b;
    scan_state_t st_step;
    logic        fail;
    logic        hit;
    logic [3:0]  hit_base;
    logic        one;
    logic [7:0]  ch;
    logic [7:0]  low;
    slot_t       len_a;
    slot_t       len_b;
    slot_t       total;

    assign pos_a = ent_pos(st.entity_progress);
    assign low   = text_byte | CH_CASE;

    always_comb begin
        hit      = 1'b0;
        hit_base = 4'd0;
        for (int p = 0; p < NUM_PAT; p++) begin
            if (!hit && PAT_TEXT[p][1] == text_byte) begin
                hit      = 1'b1;
                hit_base = PAT_BASE[p];
            end
        end
    end

    always_comb begin
        st_step = st;
        fail    = 1'b0;
        one     = 1'b0;
        ch      = text_byte;

        case (st.scan_mode)
            MODE_ENTITY: begin
                if (st.entity_progress <= 4'd1) begin
                    if (hit) begin
                        st_step.entity_progress = hit_base;
                    end else begin
                        fail = 1'b1;
                    end
                end else if (PAT_TEXT[pos_a.pat][pos_a.len] == text_byte) begin
                    if (pos_a.len + 3'd1 == PAT_LEN[pos_a.pat]) begin
                        one                     = 1'b1;
                        ch                      = PAT_VAL[pos_a.pat];
                        st_step.scan_mode       = MODE_NORMAL;
                        st_step.entity_progress = 4'd0;
                    end else begin
                        st_step.entity_progress = st.entity_progress + 4'd1;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            MODE_TAG: begin
                if (text_byte == CH_GT) begin
                    st_step.scan_mode    = MODE_NORMAL;
                    st_step.tag_progress = 2'd0;
                end else if (st.tag_progress == 2'd1) begin
                    st_step.tag_progress = (low == CH_B) ? 2'd2 : 2'd3;
                end else if (st.tag_progress == 2'd2) begin
                    if (low == CH_R) begin
                        one = 1'b1;
                        ch  = CH_LF;
                    end
                    st_step.tag_progress = 2'd3;
                end
            end
            default: begin
            end
        endcase

        // A failed prefix hands the byte back to plain text handling
        if (fail || (st.scan_mode != MODE_ENTITY && st.scan_mode != MODE_TAG)) begin
            if (fail) begin
                st_step.scan_mode       = MODE_NORMAL;
                st_step.entity_progress = 4'd0;
            end
            if (text_byte == CH_LT) begin
                st_step.scan_mode    = MODE_TAG;
                st_step.tag_progress = 2'd1;
            end else if (text_byte == CH_AMP) begin
                st_step.scan_mode       = MODE_ENTITY;
                st_step.entity_progress = 4'd1;
            end else begin
                one = 1'b1;
                ch  = text_byte;
            end
        end
    end

    assign pos_b = ent_pos(st_step.entity_progress);
    assign len_a = fail ? pos_a.len : 3'd0;
    assign len_b = (text_last && st_step.scan_mode == MODE_ENTITY) ? pos_b.len : 3'd0;
    assign total = len_a + {2'b00, one} + len_b;

    always_comb begin
        st_next = text_last ? '{MODE_NORMAL, 4'd0, 2'd0} : st_step;
    end

    always_comb begin
        grp.last   = text_last;
        grp.marker = text_last && total == 3'd0;
        grp.count  = grp.marker ? 3'd1 : total;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (grp.marker) begin
                grp.bytes[k] = 8'h00;
            end else if (3'(k) < len_a) begin
                grp.bytes[k] = PAT_TEXT[pos_a.pat][3'(k)];
            end else if (3'(k) == len_a && one) begin
                grp.bytes[k] = ch;
            end else begin
                grp.bytes[k] = PAT_TEXT[pos_b.pat][3'(k) - len_a - {2'b00, one}];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/msed_emit.sv */
// Result group holding register and output register; plays out one beat per cycle unless the output stalls.
`default_nettype none

module msed_emit
    import msed_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  result_group_t grp_in,
    output logic          load_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_byte
    output logic [1:0]    m_tuser,   // [0] has_byte, [1] run_last
    output logic          m_tlast    // text_end
);

    result_group_t grp_reg;
    slot_t         rem_reg;
    slot_t         rem_next;
    slot_t         idx_reg;
    slot_t         idx_next;
    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;
    logic [1:0]    m_tuser_reg;
    logic          m_tlast_reg;
    logic          out_free;
    logic          move;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign move       = rem_reg != 3'd0 && out_free;
    assign load_ready = rem_reg == 3'd0 || (rem_reg == 3'd1 && out_free);

    always_comb begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load) begin
            rem_next = grp_in.count;
            idx_next = 3'd0;
        end else if (move) begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= 3'd0;
            idx_reg      <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
            if (out_free) begin
                m_tvalid_reg <= move;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp_in;
        end
        if (move) begin
            m_tdata_reg <= grp_reg.bytes[idx_reg];
            m_tuser_reg <= {rem_reg == 3'd1, !grp_reg.marker};
            m_tlast_reg <= rem_reg == 3'd1 && grp_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* sv/markup_strip_entity_decode.sv */
// Subtitle markup stripper and HTML entity decoder, one text byte per input beat.
//
// Each input beat carries one text byte on s_tdata and marks the final byte of
// a text with s_tlast. Markup from '<' to '>' is dropped; a tag that opens with
// "<br" (any case) gives one newline. The entities &amp; &lt; &gt; &quot; &#39;
// become & < > " '. A prefix that stops matching is passed through as typed,
// and the byte that broke it is scanned again as plain text. On the final byte
// a pending prefix is flushed, an open tag is dropped and the scanner returns
// to its reset state; if the final byte gives no character, one beat with
// has_byte low marks the end of text. Output beats carry the character on
// m_tdata, has_byte and run_last (last beat caused by that input byte) on
// m_tuser, and end of text on m_tlast. Rate: while the output is not stalled,
// plain text streams at one byte per clock; a byte that gives several
// characters (up to six, when a broken prefix is played back) stalls the
// input while the result group drains through the single output register.
// The first output beat passes through the group register and then the
// output register. While a finished beat waits on the output, the input
// still takes any bytes that give no character and one byte that gives
// characters, then stalls until the output moves again.
`default_nettype none

module markup_strip_entity_decode
    import msed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // text_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] has_byte, [1] run_last
    output logic       m_tlast    // text_end
);

    scan_state_t   st_reg;
    scan_state_t   st_next;
    result_group_t grp;
    logic          accept;
    logic          load_ready;

    // Accept a byte whenever the group register is empty or frees this cycle
    assign s_tready = load_ready;
    assign accept   = s_tvalid && s_tready;

    msed_decode u_decode (
        .st        (st_reg),
        .text_byte (s_tdata),
        .text_last (s_tlast),
        .st_next   (st_next),
        .grp       (grp)
    );

    // Advance the scanner state on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{MODE_NORMAL, 4'd0, 2'd0};
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    // A group with no characters loads as empty, except an end marker, which holds one beat
    msed_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .grp_in     (grp),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* sv/msed_checker.sv */
// Port-level checks for the markup stripper, bound to the top level.
`default_nettype none

module msed_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // Hold a stalled output beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // An end marker carries no character and closes both the byte and the text
    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1] && m_tlast && m_tdata == 8'h00)
        else $error("malformed end marker");

    // End of text only on the last beat of a byte
    a_end_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("text end without run end");

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind markup_strip_entity_decode msed_checker u_msed_checker (.*);

`default_nettype wire

/* dv/tb_markup_strip_entity_decode.sv */
// Self-checking testbench for the subtitle markup stripper and entity decoder.
`timescale 1ns / 1ps

module tb_markup_strip_entity_decode;
    import msed_pkg::*;

    // One output beat as seen on m_tdata, m_tuser and m_tlast
    typedef struct packed {
        logic [7:0] ch;        // out_byte
        logic       has;       // has_byte
        logic       run_last;  // last beat caused by one input byte
        logic       text_end;  // last beat of the final input byte
    } beat_t;

    // One stimulus row: an input beat, plus a hand-written expected beat for
    // rows whose result is obvious on sight
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        beat_t      want;
    } row_t;

    // Progress through the opening of a tag
    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_OPENED,
        TAG_SAW_B,
        TAG_CHECKED
    } tag_step_t;

    localparam int    NUM_DIRECTED = 24;
    localparam int    NUM_RANDOM   = 450;
    localparam int    HOLD_CYCLES  = 300;
    localparam beat_t NO_BEAT      = '0;
    localparam beat_t END_MARK     = '{8'h00, 1'b0, 1'b1, 1'b1};

    // Directed rows: extremes, a complete &lt; entity, a broken &quot; prefix
    // that replays the longest literal, a line-break tag, an open tag on the
    // final byte (bare end marker) and a prefix pending on the final byte.
    localparam row_t DIRECTED [NUM_DIRECTED] = '{
        '{"A",   1'b0, 1'b1, '{"A",   1'b1, 1'b1, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
        '{8'h01, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b1, 1'b1}},
        '{"&",   1'b0, 1'b0, NO_BEAT},
        '{"l",   1'b0, 1'b0, NO_BEAT},
        '{"t",   1'b0, 1'b0, NO_BEAT},
        '{";",   1'b0, 1'b0, NO_BEAT},
        '{"&",   1'b0, 1'b0, NO_BEAT},
        '{"q",   1'b0, 1'b0, NO_BEAT},
        '{"u",   1'b0, 1'b0, NO_BEAT},
        '{"o",   1'b0, 1'b0, NO_BEAT},
        '{"t",   1'b0, 1'b0, NO_BEAT},
        '{"x",   1'b0, 1'b0, NO_BEAT},
        '{"<",   1'b0, 1'b0, NO_BEAT},
        '{"B",   1'b0, 1'b0, NO_BEAT},
        '{"r",   1'b0, 1'b0, NO_BEAT},
        '{">",   1'b0, 1'b0, NO_BEAT},
        '{"<",   1'b0, 1'b0, NO_BEAT},
        '{"b",   1'b1, 1'b1, END_MARK},
        '{"&",   1'b1, 1'b1, '{"&",   1'b1, 1'b1, 1'b1}},
        '{"&",   1'b0, 1'b0, NO_BEAT},
        '{"#",   1'b0, 1'b0, NO_BEAT},
        '{"&",   1'b1, 1'b0, NO_BEAT},
        '{">",   1'b1, 1'b1, '{">",   1'b1, 1'b1, 1'b1}}
    };

    // DUT ports; the inputs driven here are known from time zero
    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // Scoreboard
    beat_t      decoded_beats_q[$];
    int         mismatches = 0;

    // Shared pacing controls
    bit         quiet      = 1'b0;  // no idling on either side while set
    bit         hold_go    = 1'b0;  // ask the receiver for its long hold-off
    bit         hold_done  = 1'b0;

    // Decoder model state
    mode_t      scan;
    tag_step_t  tag_step;
    int         ent_pat;            // entity being matched
    int         ent_seen;           // bytes of it matched, '&' included
    logic [7:0] step_chars[$];      // characters caused by the current byte
    beat_t      step_beats[$];      // beats caused by the current byte

    row_t       random_rows[$];

    markup_strip_entity_decode dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function string ent_spelling(input int p);
        case (p)
            0:       return "&amp;";
            1:       return "&lt;";
            2:       return "&gt;";
            3:       return "&quot;";
            default: return "&#39;";
        endcase
    endfunction

    function logic [7:0] ent_value(input int p);
        case (p)
            0:       return "&";
            1:       return "<";
            2:       return ">";
            3:       return 8'h22;
            default: return 8'h27;
        endcase
    endfunction

    // Replay a broken or pending entity prefix as typed
    function void replay_prefix();
        string sp;
        sp = ent_spelling(ent_pat);
        for (int i = 0; i < ent_seen; i++) step_chars.push_back(sp[i]);
        scan     = MODE_NORMAL;
        ent_seen = 0;
    endfunction

    function void scan_plain(input logic [7:0] c);
        if (c == "<") begin
            scan     = MODE_TAG;
            tag_step = TAG_OPENED;
        end else if (c == "&") begin
            scan     = MODE_ENTITY;
            ent_seen = 1;
        end else begin
            step_chars.push_back(c);
        end
    endfunction

    function void model_reset();
        scan     = MODE_NORMAL;
        tag_step = TAG_NONE;
        ent_pat  = 0;
        ent_seen = 0;
    endfunction

    // Advance the model by one input byte and fill step_beats
    function void decode_text_byte(input logic [7:0] c, input logic last);
        string      sp;
        logic [7:0] low;
        bit         taken;
        step_chars.delete();
        step_beats.delete();
        low   = c | 8'h20;
        taken = 1'b0;
        case (scan)
            MODE_ENTITY: begin
                if (ent_seen == 1) begin
                    for (int p = 0; p < 5; p++) begin
                        sp = ent_spelling(p);
                        if (!taken && sp[1] == c) begin
                            ent_pat  = p;
                            ent_seen = 2;
                            taken    = 1'b1;
                        end
                    end
                end else begin
                    sp = ent_spelling(ent_pat);
                    if (sp[ent_seen] == c) begin
                        taken = 1'b1;
                        if (ent_seen + 1 == sp.len()) begin
                            step_chars.push_back(ent_value(ent_pat));
                            scan     = MODE_NORMAL;
                            ent_seen = 0;
                        end else begin
                            ent_seen++;
                        end
                    end
                end
                // A byte that breaks the prefix is scanned again as text
                if (!taken) begin
                    replay_prefix();
                    scan_plain(c);
                end
            end
            MODE_TAG: begin
                if (c == ">") begin
                    scan     = MODE_NORMAL;
                    tag_step = TAG_NONE;
                end else if (tag_step == TAG_OPENED) begin
                    tag_step = (low == CH_B) ? TAG_SAW_B : TAG_CHECKED;
                end else if (tag_step == TAG_SAW_B) begin
                    if (low == CH_R) step_chars.push_back(CH_LF);
                    tag_step = TAG_CHECKED;
                end
            end
            default: scan_plain(c);
        endcase

        if (last) begin
            if (scan == MODE_ENTITY) replay_prefix();
            model_reset();
            if (step_chars.size() == 0) step_beats.push_back(END_MARK);
        end
        for (int k = 0; k < step_chars.size(); k++) begin
            step_beats.push_back('{step_chars[k], 1'b1, k == step_chars.size() - 1,
                                   last && (k == step_chars.size() - 1)});
        end
    endfunction

    // ------------------------------------------------------------------
    // Random text: mostly well-formed tokens with random content, the rest
    // broken prefixes and stray special characters
    // ------------------------------------------------------------------

    function void add_random_byte(input logic [7:0] c);
        random_rows.push_back('{c, $urandom_range(99) < 3, 1'b0, NO_BEAT});
    endfunction

    function void build_random_text();
        string      sp;
        logic [7:0] c;
        int         kind;
        int         p;
        int         n;
        while (random_rows.size() < NUM_RANDOM) begin
            kind = $urandom_range(99);
            p    = $urandom_range(4);
            sp   = ent_spelling(p);
            if (kind < 30) begin
                add_random_byte(8'($urandom_range(1, 255)));
            end else if (kind < 55) begin
                for (int i = 0; i < sp.len(); i++) add_random_byte(sp[i]);
            end else if (kind < 70) begin
                n = $urandom_range(1, sp.len() - 1);
                for (int i = 0; i < n; i++) add_random_byte(sp[i]);
                add_random_byte(8'($urandom_range(1, 255)));
            end else if (kind < 90) begin
                add_random_byte("<");
                case ($urandom_range(2))
                    0: begin
                        add_random_byte($urandom_range(1) ? "B" : "b");
                        add_random_byte($urandom_range(1) ? "R" : "r");
                    end
                    1: add_random_byte($urandom_range(1) ? "B" : "b");
                    default: ;
                endcase
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) begin
                    c = 8'($urandom_range(8'h21, 8'h7E));
                    add_random_byte(c == ">" ? "x" : c);
                end
                if ($urandom_range(9) != 0) add_random_byte(">");
            end else begin
                case ($urandom_range(5))
                    0:       c = "&";
                    1:       c = "<";
                    2:       c = ">";
                    3:       c = ";";
                    4:       c = "#";
                    default: c = 8'($urandom_range(1, 255));
                endcase
                add_random_byte(c);
            end
            // End a text now and then on a token boundary
            if ($urandom_range(5) == 0) random_rows[random_rows.size() - 1].last = 1'b1;
        end
        random_rows[random_rows.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one beat, hold it until accepted, then maybe idle
    // ------------------------------------------------------------------

    task offer_row(input row_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= r.ch;
        s_tlast  <= r.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Accepted at this edge: advance the model and queue what it predicts
        decode_text_byte(r.ch, r.last);
        if (r.typed) begin
            decoded_beats_q.push_back(r.want);
        end else begin
            foreach (step_beats[k]) decoded_beats_q.push_back(step_beats[k]);
        end
        if (!quiet && $urandom_range(99) < 3) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    initial begin
        model_reset();
        build_random_text();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) offer_row(DIRECTED[i]);

        foreach (random_rows[i]) begin
            if (i == 40) hold_go = 1'b1;
            quiet = (i >= 250 && i < 330);
            offer_row(random_rows[i]);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Drain: wait for every predicted beat, then a few more cycles
        while (decoded_beats_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatches == 0) begin
            $display("markup_strip_entity_decode regression: pass");
        end else begin
            $display("markup_strip_entity_decode regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random backpressure, one long hold-off so the block fills
    // ------------------------------------------------------------------

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                for (int held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= quiet || ($urandom_range(99) >= 6);
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted output beat with the oldest prediction
    // ------------------------------------------------------------------

    function void check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser[0], m_tuser[1], m_tlast};
            if (decoded_beats_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual %h", $time, got);
                mismatches++;
            end else begin
                want = decoded_beats_q.pop_front();
                check_field("out_byte", want.ch, got.ch);
                check_field("has_byte", 8'(want.has), 8'(got.has));
                check_field("run_last", 8'(want.run_last), 8'(got.run_last));
                check_field("text_end", 8'(want.text_end), 8'(got.text_end));
            end
        end
    end

    // Hard stop well past the slowest correct run
    initial begin
        #3000000;
        $display("markup_strip_entity_decode regression: fail");
        $finish;
    end

endmodule

/* markup_strip_entity_decode.f */
sv/msed_pkg.sv
sv/msed_decode.sv
sv/msed_emit.sv
sv/markup_strip_entity_decode.sv
sv/msed_checker.sv
dv/tb_markup_strip_entity_decode.sv
